// File: design/dhx_pkg.sv
// Package for the double-to-hex-text formatter: field widths, ASCII codes,
// the descriptor that travels from the classifier to the emitter, and helpers.
// No dependencies.
package dhx_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned FRAC_W      = 52;
  localparam int unsigned EXP_W       = 11;
  localparam int unsigned FRAC_DIGITS = 13;
  localparam int unsigned EXP_DIGITS  = 4;
  localparam int unsigned EXP_OFFSET  = 1023;
  localparam int unsigned SUBN_MAG    = 1022;
  localparam int unsigned IDX_W       = 4;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_P     = 7'h70;
  localparam logic [CHAR_W-1:0] CH_UP_N  = 7'h4e;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CH_I     = 7'h69;
  localparam logic [CHAR_W-1:0] CH_N     = 7'h6e;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h66;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_INF,
    KIND_NAN
  } dhx_kind_e;

  // Everything the emitter needs to spell one value.
  typedef struct packed {
    dhx_kind_e                        kind;
    logic                             neg;
    logic                             lead;
    logic [FRAC_W-1:0]                frac;
    logic [IDX_W-1:0]                 frac_last;
    logic                             exp_neg;
    logic [EXP_DIGITS-1:0][3:0]       exp_dig;
    logic [1:0]                       exp_first;
  } dhx_desc_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + CHAR_W'(nib);
    end
    return CH_A + CHAR_W'(nib - 4'd10);
  endfunction

  function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] dig);
    return CH_ZERO + CHAR_W'(dig);
  endfunction

endpackage

// File: design/dhx_if.sv
// Stream interfaces of the formatter: raw double beats in, character beats out.
// Depends on dhx_pkg for the payload widths.
interface dhx_val_if;
  logic                           valid;
  logic                           ready;
  logic [dhx_pkg::VALUE_W-1:0]    value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

interface dhx_txt_if;
  logic                           valid;
  logic                           ready;
  logic [dhx_pkg::CHAR_W-1:0]     text_char;
  logic                           last_char;
  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: design/double_to_hex_text_top.sv
// Top level of the double-to-hex-text formatter: classifier, descriptor queue
// and character emitter. Depends on dhx_pkg, dhx_if, dhx_front, dhx_fifo, dhx_back.
//
// Usage: each beat on val_i carries the 64 raw bits of an IEEE 754 double.
// The block answers with that value's hexadecimal text on txt_o, one ASCII
// character per beat, with last_char set on the final character of the value.
// Finite values read like "-0x1.8p+1"; NaN reads "NaN"; infinities read
// "inf" and "-inf". A value yields between 3 and 24 characters.
// The first character of a value passes the classifier register, the queue
// and the output register before it is shown on txt_o, when nothing is
// queued ahead of it.
// Throughput: one character per cycle while the receiver is ready; the
// single-character output register sets this.
// The classifier takes a new value every cycle while the queue has room, so
// values may be offered back to back while earlier text is still streaming.
// Reset clears the classifier valid bit, the queue pointers and the output
// valid bit; no text is pending afterwards.
// When the receiver stalls, the shown character holds, the emitter waits, the
// queue fills, and then val_i.ready drops until room frees up again.
module double_to_hex_text_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dhx_val_if.sink   val_i,
  dhx_txt_if.source txt_o
);
  import dhx_pkg::*;

  // Classifier to queue.
  logic      front_valid;
  logic      queue_ready;
  dhx_desc_t front_desc;

  // Queue to emitter.
  logic      head_valid;
  logic      head_pop;
  dhx_desc_t head_desc;

  dhx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (val_i.valid),
    .in_ready_o   (val_i.ready),
    .value_bits_i (val_i.value_bits),
    .desc_valid_o (front_valid),
    .desc_ready_i (queue_ready),
    .desc_o       (front_desc)
  );

  dhx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .data_i  (front_desc),
    .valid_o (head_valid),
    .pop_i   (head_pop),
    .data_o  (head_desc)
  );

  // The emitter reads the queue head in place and releases it with the
  // last character of the value.
  dhx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_desc),
    .pop_o        (head_pop),
    .out_valid_o  (txt_o.valid),
    .out_ready_i  (txt_o.ready),
    .text_char_o  (txt_o.text_char),
    .last_char_o  (txt_o.last_char)
  );

  // A descriptor waiting on a full queue must stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_valid && !queue_ready) |=> (front_valid && $stable(front_desc)))
    else $error("classifier descriptor changed while the queue was full");

  // The emitter only releases an entry that is really there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_valid)
    else $error("queue popped while empty");

  // An accepted value is held by the classifier in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_i.valid && val_i.ready) |=> front_valid)
    else $error("accepted value was not captured by the classifier");

  // Releasing a queue entry always loads a last character into the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |=> (txt_o.valid && txt_o.last_char))
    else $error("queue entry released without a final character");

endmodule

// File: design/dhx_front.sv
// Classifier stage: takes a raw double, splits it into kind, fraction digits
// and decimal exponent digits, and holds the descriptor until the queue takes it.
// Depends on dhx_pkg.
module dhx_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [63:0]              value_bits_i,
  output logic                     desc_valid_o,
  input  logic                     desc_ready_i,
  output dhx_pkg::dhx_desc_t       desc_o
);
  import dhx_pkg::*;

  logic              valid_q, valid_d;
  dhx_desc_t         desc_q, desc_d;
  logic              accept;
  logic [EXP_W-1:0]  efield;
  logic [FRAC_W-1:0] frac;
  logic [EXP_W-1:0]  mag;
  logic              thou;
  logic [9:0]        rem1;
  logic [3:0]        hund;
  logic [6:0]        rem2;
  logic [3:0]        tens;
  logic [3:0]        unit;

  assign in_ready_o   = !valid_q || desc_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign desc_valid_o = valid_q;
  assign desc_o       = desc_q;

  assign efield = value_bits_i[FRAC_W +: EXP_W];
  assign frac   = value_bits_i[FRAC_W-1:0];

  always_comb begin
    desc_d         = '0;
    desc_d.neg     = value_bits_i[VALUE_W-1];
    desc_d.frac    = frac;
    desc_d.lead    = (efield != '0);
    if (efield == '1) begin
      desc_d.kind = (frac != '0) ? KIND_NAN : KIND_INF;
    end else begin
      desc_d.kind = KIND_NUM;
    end

    // Index of the last nonzero digit, counted from the most significant one.
    desc_d.frac_last = '0;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (frac[FRAC_W-1-4*i -: 4] != 4'd0) begin
        desc_d.frac_last = IDX_W'(i);
      end
    end

    if (efield == '0) begin
      mag            = EXP_W'(SUBN_MAG);
      desc_d.exp_neg = 1'b1;
    end else if (efield >= EXP_W'(EXP_OFFSET)) begin
      mag            = efield - EXP_W'(EXP_OFFSET);
      desc_d.exp_neg = 1'b0;
    end else begin
      mag            = EXP_W'(EXP_OFFSET) - efield;
      desc_d.exp_neg = 1'b1;
    end

    // Decimal digits by parallel compares against each multiple.
    thou = (mag >= EXP_W'(1000));
    rem1 = thou ? 10'(mag - EXP_W'(1000)) : 10'(mag);
    hund = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem1 >= 10'(k * 100)) begin
        hund = 4'(k);
      end
    end
    rem2 = 7'(rem1 - 10'(hund) * 10'd100);
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    unit = 4'(rem2 - 7'(tens) * 7'd10);

    desc_d.exp_dig[3] = {3'b000, thou};
    desc_d.exp_dig[2] = hund;
    desc_d.exp_dig[1] = tens;
    desc_d.exp_dig[0] = unit;
    if (thou) begin
      desc_d.exp_first = 2'd3;
    end else if (hund != 4'd0) begin
      desc_d.exp_first = 2'd2;
    end else if (tens != 4'd0) begin
      desc_d.exp_first = 2'd1;
    end else begin
      desc_d.exp_first = 2'd0;
    end
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (desc_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

endmodule

// File: design/dhx_fifo.sv
// Short descriptor queue between the classifier and the emitter.
// Depends on dhx_pkg for the descriptor type.
module dhx_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                ready_o,
  input  dhx_pkg::dhx_desc_t  data_i,
  output logic                valid_o,
  input  logic                pop_i,
  output dhx_pkg::dhx_desc_t  data_o
);
  import dhx_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dhx_desc_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: design/dhx_back.sv
// Emitter: walks the descriptor at the head of the queue one character per
// beat into a registered output stage. Depends on dhx_pkg.
module dhx_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  dhx_pkg::dhx_desc_t       head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [dhx_pkg::CHAR_W-1:0] text_char_o,
  output logic                     last_char_o
);
  import dhx_pkg::*;

  typedef enum logic [3:0] {
    PH_MINUS, PH_ZERO, PH_X, PH_LEAD, PH_DOT, PH_FRAC,
    PH_P, PH_ESIGN, PH_EXP, PH_NAN, PH_INF
  } ph_e;

  ph_e                 ph_q, ph_d, cur_ph, start_ph;
  logic [IDX_W-1:0]    idx_q, idx_d, cur_idx;
  logic                started_q, started_d;
  logic                ov_q;
  logic [CHAR_W-1:0]   char_q, chr;
  logic                last_q, last;
  logic                emit;
  logic [IDX_W-1:0]    sel;
  logic [3:0]          nib;

  always_comb begin
    case (head_i.kind)
      KIND_NAN: start_ph = PH_NAN;
      KIND_INF: start_ph = head_i.neg ? PH_MINUS : PH_INF;
      default:  start_ph = head_i.neg ? PH_MINUS : PH_ZERO;
    endcase
  end

  assign cur_ph  = started_q ? ph_q : start_ph;
  assign cur_idx = started_q ? idx_q : '0;
  assign emit    = head_valid_i && (!ov_q || out_ready_i);
  assign pop_o   = emit && last;

  assign sel = IDX_W'(FRAC_DIGITS - 1) - cur_idx;
  assign nib = 4'(head_i.frac >> {sel, 2'b00});

  always_comb begin
    chr   = CH_ZERO;
    last  = 1'b0;
    ph_d  = cur_ph;
    idx_d = cur_idx + 1'b1;
    case (cur_ph)
      PH_MINUS: begin
        chr   = CH_MINUS;
        ph_d  = (head_i.kind == KIND_INF) ? PH_INF : PH_ZERO;
        idx_d = '0;
      end
      PH_ZERO: begin
        chr  = CH_ZERO;
        ph_d = PH_X;
      end
      PH_X: begin
        chr  = CH_X;
        ph_d = PH_LEAD;
      end
      PH_LEAD: begin
        chr  = head_i.lead ? CH_ONE : CH_ZERO;
        ph_d = PH_DOT;
      end
      PH_DOT: begin
        chr   = CH_DOT;
        ph_d  = PH_FRAC;
        idx_d = '0;
      end
      PH_FRAC: begin
        chr = hex_char(nib);
        if (cur_idx == head_i.frac_last) begin
          ph_d = PH_P;
        end
      end
      PH_P: begin
        chr  = CH_P;
        ph_d = PH_ESIGN;
      end
      PH_ESIGN: begin
        chr   = head_i.exp_neg ? CH_MINUS : CH_PLUS;
        ph_d  = PH_EXP;
        idx_d = IDX_W'(head_i.exp_first);
      end
      PH_EXP: begin
        chr   = dec_char(head_i.exp_dig[cur_idx[1:0]]);
        last  = (cur_idx[1:0] == 2'd0);
        idx_d = cur_idx - 1'b1;
      end
      PH_NAN: begin
        chr  = (cur_idx[1:0] == 2'd1) ? CH_A : CH_UP_N;
        last = (cur_idx[1:0] == 2'd2);
      end
      PH_INF: begin
        chr  = (cur_idx[1:0] == 2'd0) ? CH_I :
               (cur_idx[1:0] == 2'd1) ? CH_N : CH_F;
        last = (cur_idx[1:0] == 2'd2);
      end
      default: begin
        chr  = CH_ZERO;
        last = 1'b1;
      end
    endcase
  end

  assign started_d = emit ? !last : started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      ph_q      <= PH_ZERO;
      idx_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      started_q <= started_d;
      if (emit) begin
        ph_q  <= ph_d;
        idx_q <= idx_d;
        ov_q  <= 1'b1;
      end else if (out_ready_i) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= chr;
      last_q <= last;
    end
  end

  assign out_valid_o = ov_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

// File: bench/double_to_hex_text_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for double_to_hex_text_top: feeds raw binary64 patterns
// and checks every character beat against a built-in text predictor.
// Depends on dhx_pkg, dhx_if and the formatter RTL.
module double_to_hex_text_top_tb;
  import dhx_pkg::*;

  // One expected character beat of the formatted text.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  logic clk_i;
  logic rst_ni;

  dhx_val_if val_bus ();
  dhx_txt_if txt_bus ();

  double_to_hex_text_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .val_i  (val_bus),
    .txt_o  (txt_bus)
  );

  // Values waiting to be offered, and the text still owed by the block.
  logic [VALUE_W-1:0] pending_doubles[$];
  text_beat_t         expected_text[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned values_queued;
  int unsigned values_accepted;
  int unsigned chars_checked;
  int unsigned specials_seen;
  int unsigned tiny_seen;
  int unsigned error_count;
  logic        val_taken;

  // 12 ns clock, low half first.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Spells one binary64 pattern the way the formatter should and queues the
  // characters, marking the final one.
  function automatic void spell_double(input logic [VALUE_W-1:0] bits);
    logic        neg;
    logic [10:0] efield;
    logic [51:0] frac;
    string       txt;
    string       digs;
    int          e;
    byte         c;
    text_beat_t  beat;
    neg    = bits[63];
    efield = bits[62:52];
    frac   = bits[51:0];
    if (efield == 11'h7ff) begin
      specials_seen++;
      if (frac != '0) begin
        txt = "NaN";
      end else if (neg) begin
        txt = "-inf";
      end else begin
        txt = "inf";
      end
    end else begin
      if (efield == '0) begin
        tiny_seen++;
      end
      if (neg) begin
        txt = "-0x";
      end else begin
        txt = "0x";
      end
      if (efield == '0) begin
        txt = {txt, "0."};
      end else begin
        txt = {txt, "1."};
      end
      digs = $sformatf("%013h", frac);
      // Trailing zero digits go, but one digit always stays.
      while (digs.len() > 1 && digs[digs.len()-1] == "0") begin
        digs = digs.substr(0, digs.len() - 2);
      end
      e   = (efield == '0) ? -1022 : int'(efield) - 1023;
      txt = {txt, digs, "p"};
      if (e < 0) begin
        txt = {txt, "-"};
      end else begin
        txt = {txt, "+"};
      end
      txt = {txt, $sformatf("%0d", (e < 0) ? -e : e)};
    end
    for (int i = 0; i < txt.len(); i++) begin
      c         = txt[i];
      beat.ch   = c[CHAR_W-1:0];
      beat.last = (i == txt.len() - 1);
      expected_text.push_back(beat);
    end
  endfunction

  // Random pattern biased toward interesting shapes: exponents near the bias,
  // the zero and all-ones exponent fields, and fractions with trailing zeros.
  function automatic logic [VALUE_W-1:0] random_double();
    logic [63:0] raw;
    logic [63:0] keep_mask;
    logic [10:0] efield;
    logic [51:0] frac;
    int unsigned shape;
    int unsigned zero_nibs;
    raw       = {$urandom, $urandom};
    shape     = $urandom_range(9);
    zero_nibs = $urandom_range(13);
    keep_mask = ~((64'h1 << (4 * zero_nibs)) - 64'h1);
    frac      = raw[51:0] & keep_mask[51:0];
    case (shape)
      0, 1: begin
        return raw;
      end
      2: begin
        efield = '0;
      end
      3: begin
        efield = 11'h7ff;
        if ($urandom_range(1) == 0) begin
          frac = '0;
        end
      end
      4, 5: begin
        efield = 11'($urandom_range(1, 2046));
      end
      default: begin
        efield = 11'(1023 + $urandom_range(24) - 12);
      end
    endcase
    return {raw[63], efield, frac};
  endfunction

  // Input side: remember what went in and predict its text at the edge where
  // the beat is taken. Output side: compare every character beat.
  always @(posedge clk_i) begin
    text_beat_t want;
    val_taken <= val_bus.valid && val_bus.ready;
    if (rst_ni) begin
      if (val_bus.valid && val_bus.ready) begin
        spell_double(val_bus.value_bits);
        values_accepted <= values_accepted + 1;
      end
      if (txt_bus.valid && txt_bus.ready) begin
        chars_checked <= chars_checked + 1;
        if (expected_text.size() == 0) begin
          $error("unexpected character beat: text_char=0x%0h last_char=%0b",
                 txt_bus.text_char, txt_bus.last_char);
          error_count++;
        end else begin
          want = expected_text.pop_front();
          if (txt_bus.text_char !== want.ch) begin
            $error("text_char mismatch: expected 0x%0h, actual 0x%0h",
                   want.ch, txt_bus.text_char);
            error_count++;
          end
          if (txt_bus.last_char !== want.last) begin
            $error("last_char mismatch: expected %0b, actual %0b",
                   want.last, txt_bus.last_char);
            error_count++;
          end
        end
      end
    end
  end

  // Driver: inputs move on the falling edge. A beat that is still waiting
  // keeps its value; otherwise the next value is offered unless the sender
  // decides to idle, and idle cycles carry junk on the data lines.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      val_bus.valid <= 1'b0;
      txt_bus.ready <= 1'b0;
    end else begin
      if (!val_bus.valid || val_taken) begin
        if (pending_doubles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          val_bus.valid      <= 1'b1;
          val_bus.value_bits <= pending_doubles.pop_front();
        end else begin
          val_bus.valid      <= 1'b0;
          val_bus.value_bits <= {$urandom, $urandom};
        end
      end
      txt_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    val_bus.valid      = 1'b0;
    val_bus.value_bits = '0;
    txt_bus.ready      = 1'b0;
    val_taken          = 1'b0;
    values_queued      = 0;
    values_accepted    = 0;
    chars_checked      = 0;
    specials_seen      = 0;
    tiny_seen          = 0;
    error_count        = 0;
    send_idle_pct      = 19;
    recv_idle_pct      = 82;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Queue updates happen on the rising edge so they never race the driver.
    @(posedge clk_i);
    // Directed values: signed zeros, both infinities, NaN with either sign,
    // the subnormal and normal extremes, the zero exponent, and exponents of
    // one to four decimal digits of either sign.
    pending_doubles.push_back(64'h0000_0000_0000_0000);
    pending_doubles.push_back(64'h8000_0000_0000_0000);
    pending_doubles.push_back(64'h7ff0_0000_0000_0000);
    pending_doubles.push_back(64'hfff0_0000_0000_0000);
    pending_doubles.push_back(64'h7ff8_0000_0000_0000);
    pending_doubles.push_back(64'hfff0_0000_0000_0001);
    pending_doubles.push_back(64'hffff_ffff_ffff_ffff);
    pending_doubles.push_back(64'h7fef_ffff_ffff_ffff);
    pending_doubles.push_back(64'hffef_ffff_ffff_ffff);
    pending_doubles.push_back(64'h0010_0000_0000_0000);
    pending_doubles.push_back(64'h0000_0000_0000_0001);
    pending_doubles.push_back(64'h800f_ffff_ffff_ffff);
    pending_doubles.push_back(64'h3ff0_0000_0000_0000);
    pending_doubles.push_back(64'hbff8_0000_0000_0000);
    pending_doubles.push_back(64'h4000_0000_0000_0000);
    pending_doubles.push_back(64'h3fe0_0000_0000_0000);
    pending_doubles.push_back(64'h4090_0000_0000_0000);
    pending_doubles.push_back(64'h3f50_0000_0000_0000);
    pending_doubles.push_back(64'h4630_0000_0000_0000);
    pending_doubles.push_back(64'h39b0_0000_0000_0000);
    pending_doubles.push_back(64'h7e70_0000_0000_0000);
    pending_doubles.push_back(64'h0180_0000_0000_0000);
    pending_doubles.push_back(64'h3ff0_abcd_ef01_2345);
    pending_doubles.push_back(64'h5555_5555_5555_5555);
    pending_doubles.push_back(64'haaaa_aaaa_aaaa_aaaa);
    for (int i = 0; i < 20; i++) begin
      pending_doubles.push_back(random_double());
    end
    values_queued = pending_doubles.size();
    while (values_accepted != values_queued) @(negedge clk_i);

    // Slow sender, eager receiver.
    @(posedge clk_i);
    send_idle_pct = 82;
    recv_idle_pct = 19;
    for (int i = 0; i < 37; i++) begin
      pending_doubles.push_back(random_double());
    end
    values_queued += 37;
    while (values_accepted != values_queued) @(negedge clk_i);

    // Full speed on both sides.
    @(posedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 37; i++) begin
      pending_doubles.push_back(random_double());
    end
    values_queued += 37;
    while (values_accepted != values_queued) @(negedge clk_i);

    while (expected_text.size() != 0) @(negedge clk_i);
    // Give a stray extra character a chance to show up.
    repeat (30) @(negedge clk_i);

    $display("Formatted %0d values (%0d NaN or infinity, %0d zero or subnormal);",
             values_accepted, specials_seen, tiny_seen);
    $display("checked %0d character beats across three handshake pacing phases.",
             chars_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out waiting for the formatter.");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
design/dhx_pkg.sv
design/dhx_if.sv
design/dhx_front.sv
design/dhx_fifo.sv
design/dhx_back.sv
design/double_to_hex_text_top.sv
bench/double_to_hex_text_top_tb.sv
